### hw/rtl/eci_pkg.sv
// Package: types, constants and curve codes for the easing curve interpolator.
package eci_pkg;

   localparam int FUNC_W     = 4;
   localparam int TIME_W     = 17;
   localparam int VALUE_W    = 32;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 32;

   // Q1.16 landmarks
   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [16:0] HALF_Q16 = 17'd32768;

   // back curve constants, Q16
   localparam logic [17:0] BACK_C1   = 18'd111515;
   localparam logic [17:0] BACK_C3   = 18'd177051;
   localparam logic [17:0] BACK_C2   = 18'd170060;
   localparam logic [17:0] BACK_C2P1 = 18'd235596;

   // bounce segment edges and centers, scaled by 11 (so 11*t is compared)
   localparam logic [19:0] BOUNCE_EDGE1 = 20'd262144;
   localparam logic [19:0] BOUNCE_EDGE2 = 20'd524288;
   localparam logic [19:0] BOUNCE_EDGE3 = 20'd655360;
   localparam logic [19:0] BOUNCE_K2    = 20'd393216;
   localparam logic [19:0] BOUNCE_K3    = 20'd589824;
   localparam logic [19:0] BOUNCE_K4    = 20'd688128;
   localparam logic [15:0] BOUNCE_A     = 16'd49152;
   localparam logic [15:0] BOUNCE_B     = 16'd61440;
   localparam logic [15:0] BOUNCE_C     = 16'd64512;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LINEAR      = 4'd0,
      FUNC_INQUAD      = 4'd1,
      FUNC_OUTQUAD     = 4'd2,
      FUNC_INOUTQUAD   = 4'd3,
      FUNC_OUTBOUNCE   = 4'd4,
      FUNC_INBOUNCE    = 4'd5,
      FUNC_INOUTBOUNCE = 4'd6,
      FUNC_INBACK      = 4'd7,
      FUNC_OUTBACK     = 4'd8,
      FUNC_INOUTBACK   = 4'd9,
      FUNC_GOBACK      = 4'd10
   } func_type;

   // per-item context that rides along the pipeline
   typedef struct packed {
      func_type           func;
      logic               half;
      logic [16:0]        tc;
      logic [16:0]        x;
      logic signed [31:0] base;
      logic signed [32:0] diff;
      logic [15:0]        off;
      logic [16:0]        q;
   } ctx_type;

endpackage

### hw/rtl/easing_curve_interpolator_top.sv
// Top level: pipelined fixed-point easing curve interpolator.
//
// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+---------------------------------------------
// req     | in  | req_tvalid/req_tready  | tuser: func; tdata: time_rate, start, end
// rsp     | out | rsp_tvalid/rsp_tready  | tdata: eased_value; tuser: saturated
//
// One transaction enters per cycle while req_tready is high; the accepting edge loads the first
// of ten pipeline register stages, and the result passes through stages 2 to 10 and then the
// output register before it shows on rsp. The longest stage holds one multiplier or one wide add
// and compare.
// Reset (synchronous, active high) clears all valid bits; payload registers are not reset.
// A stalled rsp fills a one-entry skid register behind the output register; req_tready
// drops only while that skid entry is occupied, and the whole pipeline holds with it.
module easing_curve_interpolator_top
   import eci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [16:0] time_rate, [48:17] start_value, [80:49] end_value, [87:81] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [3:0] func
   input  logic [FUNC_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] eased_value
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] saturated
   output logic [0:0]            rsp_tuser
);

   localparam int NSTAGE = 10;

   // pipeline-wide advance: hold everything while the skid entry is busy
   logic en;
   logic push;

   logic [NSTAGE:1] vld_ff;
   ctx_type         ctx_ff [1:NSTAGE];
   ctx_type         ctx_in;

   logic                   out_vld_ff;
   logic                   skid_vld_ff;
   logic signed [31:0]     out_value_ff;
   logic                   out_sat_ff;
   logic signed [31:0]     skid_value_ff;
   logic                   skid_sat_ff;

   // ---------------- stage 1: clamp t, pick the curve argument, form base/diff
   logic [16:0]        req_time;
   logic signed [31:0] req_start;
   logic signed [31:0] req_end;
   logic [16:0]        tc_in;
   logic               half_in;
   logic [17:0]        two_t;
   logic [16:0]        one_minus_t;
   logic [17:0]        one_minus_2t;
   logic [17:0]        two_t_minus_1;
   logic [17:0]        two_one_minus;
   logic [16:0]        x_in;
   logic signed [32:0] start_ext;
   logic signed [32:0] end_ext;
   func_type           func_in;

   assign req_time  = req_tdata[16:0];
   assign req_start = $signed(req_tdata[48:17]);
   assign req_end   = $signed(req_tdata[80:49]);
   assign func_in   = func_type'(req_tuser);

   always_comb begin
      tc_in         = (req_time > ONE_Q16) ? ONE_Q16 : req_time;
      half_in       = (tc_in < HALF_Q16);
      two_t         = {tc_in, 1'b0};
      one_minus_t   = ONE_Q16 - tc_in;
      one_minus_2t  = 18'(ONE_Q16) - two_t;
      two_t_minus_1 = two_t - 18'(ONE_Q16);
      two_one_minus = {one_minus_t, 1'b0};
      start_ext     = 33'(req_start);
      end_ext       = 33'(req_end);

      case (func_in) inside
         FUNC_OUTQUAD, FUNC_INBOUNCE, FUNC_OUTBACK: x_in = one_minus_t;
         FUNC_INOUTQUAD:   x_in = half_in ? tc_in : one_minus_t;
         FUNC_INOUTBOUNCE: x_in = half_in ? one_minus_2t[16:0] : two_t_minus_1[16:0];
         FUNC_INOUTBACK:   x_in = half_in ? two_t[16:0] : two_one_minus[16:0];
         FUNC_GOBACK:      x_in = half_in ? two_t[16:0] : two_t_minus_1[16:0];
         default:          x_in = tc_in;
      endcase

      ctx_in      = '0;
      ctx_in.func = func_in;
      ctx_in.half = half_in;
      ctx_in.tc   = tc_in;
      ctx_in.x    = x_in;
      // go-and-back returns from end toward start in its second half
      if (func_in == FUNC_GOBACK && !half_in) begin
         ctx_in.base = req_end;
         ctx_in.diff = start_ext - end_ext;
      end else begin
         ctx_in.base = req_start;
         ctx_in.diff = end_ext - start_ext;
      end
   end

   // ---------------- stage 2: bounce segment select, offset d = 11x - k
   logic [19:0]        e11;
   logic [19:0]        bk;
   logic [15:0]        off_in;
   logic signed [20:0] m_in;
   logic signed [20:0] m_ff;
   logic               bounce2;

   always_comb begin
      e11 = (20'(ctx_ff[1].x) << 3) + (20'(ctx_ff[1].x) << 1) + 20'(ctx_ff[1].x);
      if (e11 < BOUNCE_EDGE1) begin
         bk     = '0;
         off_in = '0;
      end else if (e11 < BOUNCE_EDGE2) begin
         bk     = BOUNCE_K2;
         off_in = BOUNCE_A;
      end else if (e11 < BOUNCE_EDGE3) begin
         bk     = BOUNCE_K3;
         off_in = BOUNCE_B;
      end else begin
         bk     = BOUNCE_K4;
         off_in = BOUNCE_C;
      end
      bounce2 = (ctx_ff[1].func == FUNC_OUTBOUNCE) || (ctx_ff[1].func == FUNC_INBOUNCE) ||
                (ctx_ff[1].func == FUNC_INOUTBOUNCE);
      m_in = bounce2 ? ($signed({1'b0, e11}) - $signed({1'b0, bk}))
                     : $signed({4'b0, ctx_ff[1].x});
   end

   // ---------------- stage 3: square, and (c2+1)*u for in-out back
   logic signed [41:0] sq_full;
   logic [34:0]        p9_full;
   logic [36:0]        sq_ff;
   logic [33:0]        p9_ff;

   assign sq_full = 42'(m_ff) * 42'(m_ff);
   assign p9_full = 35'(BACK_C2P1) * 35'(ctx_ff[2].x);

   // ---------------- stage 4: round the square, form the in-out back inner term
   logic [37:0]        sq_r15;
   logic [37:0]        sq_r16;
   logic [37:0]        sq_r20;
   logic [16:0]        q_in;
   logic [34:0]        p9_r;
   logic signed [18:0] inner_in;
   logic signed [18:0] inner_ff;
   logic               bounce4;

   always_comb begin
      sq_r15  = (38'(sq_ff) + 38'd16384) >> 15;
      sq_r16  = (38'(sq_ff) + 38'd32768) >> 16;
      sq_r20  = (38'(sq_ff) + 38'd524288) >> 20;
      bounce4 = (ctx_ff[3].func == FUNC_OUTBOUNCE) || (ctx_ff[3].func == FUNC_INBOUNCE) ||
                (ctx_ff[3].func == FUNC_INOUTBOUNCE);
      if (ctx_ff[3].func == FUNC_INOUTQUAD) begin
         q_in = sq_r15[16:0];
      end else if (bounce4) begin
         q_in = sq_r20[16:0];
      end else begin
         q_in = sq_r16[16:0];
      end
      p9_r     = (35'({1'b0, p9_ff}) + 35'd32768) >> 16;
      inner_in = $signed({1'b0, p9_r[17:0]}) - $signed({1'b0, BACK_C2});
   end

   // ---------------- stage 5: t2*t for back, u2*inner for in-out back
   logic signed [18:0] mul_b;
   logic signed [37:0] p2_full;
   logic signed [35:0] p2_ff;

   always_comb begin
      if (ctx_ff[4].func == FUNC_INBACK || ctx_ff[4].func == FUNC_OUTBACK) begin
         mul_b = $signed({2'b0, ctx_ff[4].x});
      end else begin
         mul_b = inner_ff;
      end
      p2_full = 38'($signed({1'b0, ctx_ff[4].q})) * 38'(mul_b);
   end

   // ---------------- stage 6: round to t3 (shift 16) or g (shift 17)
   logic signed [35:0] r2_16;
   logic signed [35:0] r2_17;
   logic signed [18:0] r2_in;
   logic signed [18:0] r2_ff;

   always_comb begin
      r2_16 = (p2_ff + 36'sd32768) >>> 16;
      r2_17 = (p2_ff + 36'sd65536) >>> 17;
      r2_in = (ctx_ff[5].func == FUNC_INOUTBACK) ? r2_17[18:0] : r2_16[18:0];
   end

   // ---------------- stage 7: c3*t3 and c1*t2
   logic signed [37:0] pa_full;
   logic signed [37:0] pb_full;
   logic signed [36:0] pa_ff;
   logic signed [36:0] pb_ff;
   logic signed [18:0] g_ff;

   assign pa_full = 38'(r2_ff) * 38'($signed({1'b0, BACK_C3}));
   assign pb_full = 38'($signed({1'b0, ctx_ff[6].q})) * 38'($signed({1'b0, BACK_C1}));

   // ---------------- stage 8: round the back polynomial, or pass g through
   logic signed [37:0] back_sum;
   logic signed [37:0] back_sh;
   logic signed [18:0] rb_in;
   logic signed [18:0] rb_ff;

   always_comb begin
      back_sum = 38'(pa_ff) - 38'(pb_ff) + 38'sd32768;
      back_sh  = back_sum >>> 16;
      rb_in    = (ctx_ff[7].func == FUNC_INOUTBACK) ? g_ff : back_sh[18:0];
   end

   // ---------------- stage 9: assemble f(t) per curve
   localparam logic signed [18:0] ONE_S = 19'sd65536;
   logic signed [18:0] qs;
   logic signed [18:0] bq;
   logic signed [18:0] bh_lo;
   logic signed [18:0] bh_hi;
   logic signed [18:0] f_in;
   logic signed [18:0] f_ff;

   always_comb begin
      qs    = $signed({2'b0, ctx_ff[8].q});
      bq    = qs + $signed({3'b0, ctx_ff[8].off});
      bh_lo = (ONE_S - bq + 19'sd1) >>> 1;
      bh_hi = (ONE_S + bq + 19'sd1) >>> 1;
      case (ctx_ff[8].func) inside
         FUNC_LINEAR:               f_in = $signed({2'b0, ctx_ff[8].tc});
         FUNC_INQUAD, FUNC_GOBACK:  f_in = qs;
         FUNC_OUTQUAD:              f_in = ONE_S - qs;
         FUNC_INOUTQUAD:            f_in = ctx_ff[8].half ? qs : ONE_S - qs;
         FUNC_OUTBOUNCE:            f_in = bq;
         FUNC_INBOUNCE:             f_in = ONE_S - bq;
         FUNC_INOUTBOUNCE:          f_in = ctx_ff[8].half ? bh_lo : bh_hi;
         FUNC_INBACK:               f_in = rb_ff;
         FUNC_OUTBACK:              f_in = ONE_S - rb_ff;
         FUNC_INOUTBACK:            f_in = ctx_ff[8].half ? rb_ff : ONE_S - rb_ff;
         default:                   f_in = '0;
      endcase
   end

   // ---------------- stage 10: diff * f
   logic signed [51:0] prod_in;
   logic signed [51:0] prod_ff;

   assign prod_in = 52'($signed(ctx_ff[9].diff)) * 52'(f_ff);

   // ---------------- output stage: base + rnd(prod), saturate to 32 bits
   logic signed [52:0] acc;
   logic signed [52:0] res;
   logic signed [31:0] res_value;
   logic               res_sat;

   always_comb begin
      acc = (53'($signed(ctx_ff[10].base)) <<< 16) + 53'(prod_ff) + 53'sd32768;
      res = acc >>> 16;
      if (res > 53'sd2147483647) begin
         res_value = 32'sh7fffffff;
         res_sat   = 1'b1;
      end else if (res < -53'sd2147483648) begin
         res_value = 32'sh80000000;
         res_sat   = 1'b1;
      end else begin
         res_value = res[31:0];
         res_sat   = 1'b0;
      end
   end

   assign en         = !skid_vld_ff;
   assign push       = en && vld_ff[NSTAGE];
   assign req_tready = en;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_sat_ff;

   // valid bits and output/skid occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[NSTAGE-1:1], req_tvalid};
         end
         if (!out_vld_ff || rsp_tready) begin
            // output register free: refill from skid first, else from the pipe
            out_vld_ff  <= skid_vld_ff || push;
            skid_vld_ff <= 1'b0;
         end else if (push) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   // context entering stages 3 and 5 picks up the offset and the rounded square
   ctx_type ctx2_in;
   ctx_type ctx4_in;

   always_comb begin
      ctx2_in     = ctx_ff[1];
      ctx2_in.off = off_in;
      ctx4_in     = ctx_ff[3];
      ctx4_in.q   = q_in;
   end

   // pipeline payload, advanced as one
   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[1] <= ctx_in;
         ctx_ff[2] <= ctx2_in;
         ctx_ff[3] <= ctx_ff[2];
         ctx_ff[4] <= ctx4_in;
         for (int i = 5; i <= NSTAGE; i++) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
         m_ff     <= m_in;
         sq_ff    <= sq_full[36:0];
         p9_ff    <= p9_full[33:0];
         inner_ff <= inner_in;
         p2_ff    <= p2_full[35:0];
         r2_ff    <= r2_in;
         pa_ff    <= pa_full[36:0];
         pb_ff    <= pb_full[36:0];
         g_ff     <= r2_ff;
         rb_ff    <= rb_in;
         f_ff     <= f_in;
         prod_ff  <= prod_in;
      end
   end

   // output register and skid entry payload
   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         out_value_ff <= skid_vld_ff ? skid_value_ff : res_value;
         out_sat_ff   <= skid_vld_ff ? skid_sat_ff : res_sat;
      end else if (push) begin
         skid_value_ff <= res_value;
         skid_sat_ff   <= res_sat;
      end
   end

`ifndef SYNTHESIS
   // skid entry only fills behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry valid while output register empty");

   // skid fills only when a held result blocks the output
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(out_vld_ff && !rsp_tready && vld_ff[NSTAGE]))
      else $error("skid entry filled without an output stall");

   // curves other than back stay within [0, 1]
   a_f_range: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[9] && !(ctx_ff[9].func == FUNC_INBACK || ctx_ff[9].func == FUNC_OUTBACK ||
                      ctx_ff[9].func == FUNC_INOUTBACK))
      |-> (f_ff >= 19'sd0 && f_ff <= ONE_S))
      else $error("curve value out of range for a non-back curve");

   // a saturated result is one of the two rails
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 32'h7fffffff || rsp_tdata == 32'h80000000))
      else $error("saturation flag set on a value that is not a rail");

   // an accepted transaction lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[1])
      else $error("accepted transaction lost at pipeline entry");
`endif

endmodule

### bench/tb_top.sv
// Testbench for the easing curve interpolator: random and corner-case items checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
   import eci_pkg::*;

   // selector codes past the last curve; the block returns start_value for these
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd11;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic [16:0]        TIME_MAX  = 17'h1FFFF;

   typedef struct {
      logic signed [31:0] value;
      logic               sat;
   } eased_result_type;

   // Keeps the results still owed by the block and compares each delivered one.
   class eased_value_tracker;
      localparam longint Q_ONE = 65536;
      localparam longint C1    = 111515;
      localparam longint C2    = 170060;
      localparam longint C3    = 177051;
      localparam longint B_OFF = 49152;
      localparam longint C_OFF = 61440;
      localparam longint D_OFF = 64512;

      eased_result_type owed_results[$];
      int unsigned      mismatches;

      // add half an LSB, then floor
      function longint rnd(longint v, int unsigned s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint square_q16(longint t);
         return rnd(t * t, 16);
      endfunction

      function longint bounce(longint t);
         longint d;
         if (t * 11 < 4 * Q_ONE) begin
            return rnd(121 * t * t, 20);
         end
         if (t * 11 < 8 * Q_ONE) begin
            d = 11 * t - 6 * Q_ONE;
            return rnd(d * d, 20) + B_OFF;
         end
         if (t * 11 < 10 * Q_ONE) begin
            d = 11 * t - 9 * Q_ONE;
            return rnd(d * d, 20) + C_OFF;
         end
         d = 22 * t - 21 * Q_ONE;
         return rnd(d * d, 22) + D_OFF;
      endfunction

      function longint back_in(longint t);
         longint t2;
         longint t3;
         t2 = rnd(t * t, 16);
         t3 = rnd(t2 * t, 16);
         return rnd(C3 * t3 - C1 * t2, 16);
      endfunction

      function longint back_mid(longint u);
         longint u2;
         longint inner;
         u2    = rnd(u * u, 16);
         inner = rnd((C2 + Q_ONE) * u, 16) - C2;
         return rnd(u2 * inner, 17);
      endfunction

      function eased_result_type eased_for(logic [3:0] fn, logic [16:0] time_rate,
                                           logic signed [31:0] start_v,
                                           logic signed [31:0] end_v);
         longint           t;
         longint           base;
         longint           diff;
         longint           f;
         longint           r;
         eased_result_type res;
         t    = longint'(time_rate);
         base = longint'(start_v);
         diff = longint'(end_v) - longint'(start_v);
         if (t > Q_ONE) begin
            t = Q_ONE;
         end
         case (fn)
            FUNC_LINEAR:    f = t;
            FUNC_INQUAD:    f = square_q16(t);
            FUNC_OUTQUAD:   f = Q_ONE - square_q16(Q_ONE - t);
            FUNC_INOUTQUAD: f = (t < Q_ONE / 2) ? rnd(t * t, 15)
                                 : Q_ONE - rnd((Q_ONE - t) * (Q_ONE - t), 15);
            FUNC_OUTBOUNCE: f = bounce(t);
            FUNC_INBOUNCE:  f = Q_ONE - bounce(Q_ONE - t);
            FUNC_INOUTBOUNCE: begin
               if (t < Q_ONE / 2) begin
                  f = rnd(Q_ONE - bounce(Q_ONE - 2 * t), 1);
               end else begin
                  f = rnd(Q_ONE + bounce(2 * t - Q_ONE), 1);
               end
            end
            FUNC_INBACK:    f = back_in(t);
            FUNC_OUTBACK:   f = Q_ONE - back_in(Q_ONE - t);
            FUNC_INOUTBACK: f = (t < Q_ONE / 2) ? back_mid(2 * t)
                                 : Q_ONE - back_mid(2 * (Q_ONE - t));
            FUNC_GOBACK: begin
               // second half runs from end back to start
               if (t < Q_ONE / 2) begin
                  f = square_q16(2 * t);
               end else begin
                  base = longint'(end_v);
                  diff = longint'(start_v) - longint'(end_v);
                  f    = square_q16(2 * t - Q_ONE);
               end
            end
            default:        f = 0;
         endcase
         r       = base + rnd(diff * f, 16);
         res.sat = 1'b0;
         if (r > longint'(VALUE_MAX)) begin
            r       = longint'(VALUE_MAX);
            res.sat = 1'b1;
         end else if (r < longint'(VALUE_MIN)) begin
            r       = longint'(VALUE_MIN);
            res.sat = 1'b1;
         end
         res.value = r[31:0];
         return res;
      endfunction

      function void note_request(logic [3:0] fn, logic [16:0] time_rate,
                                 logic signed [31:0] start_v, logic signed [31:0] end_v);
         owed_results.push_back(eased_for(fn, time_rate, start_v, end_v));
      endfunction

      function void check_result(logic [31:0] value, logic sat);
         eased_result_type want;
         if (owed_results.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected result: value %h sat %b", value, sat);
            end
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         if (value !== want.value || sat !== want.sat) begin
            if (mismatches < 10) begin
               $display("mismatch: value exp %h got %h, sat exp %b got %b",
                        want.value, value, want.sat, sat);
            end
            mismatches++;
         end
      endfunction

      function int outstanding();
         return owed_results.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;

   eased_value_tracker tracker;
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_idle_pct = 0;
   bit                 long_hold_req = 1'b0;
   int unsigned        hold_left = 0;

   easing_curve_interpolator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random back-pressure, plus one long hold on request so the pipe fills.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = 299;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Sample both channels at the rising edge; a transaction moves when valid and ready.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.note_request(req_tuser, req_tdata[16:0],
                                 $signed(req_tdata[48:17]), $signed(req_tdata[80:49]));
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_result(rsp_tdata, rsp_tuser[0]);
         end
      end
   end

   // Offer one item from a falling edge; return at the falling edge after its transaction.
   task automatic send_item(input logic [3:0] fn, input logic [16:0] t,
                            input logic signed [31:0] start_v,
                            input logic signed [31:0] end_v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {7'd0, end_v, start_v, t};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
         1:       return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_item();
      logic [3:0]  fn;
      logic [16:0] t;
      fn = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI))
                                       : 4'($urandom_range(FUNC_LINEAR, FUNC_GOBACK));
      case ($urandom_range(0, 15)) inside
         0, 1:    t = 17'($urandom_range(65537, TIME_MAX));
         2:       t = ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0;
         3:       t = 17'(17'd32768 + $urandom_range(0, 2) - 1);
         default: t = 17'($urandom_range(0, 65536));
      endcase
      send_item(fn, t, pick_value(), pick_value());
   endtask

   initial begin
      logic [16:0] corner_t[4];
      logic [16:0] bounce_edge[6];
      logic [3:0]  fn;
      corner_t    = '{17'd0, 17'd65536, TIME_MAX, 17'd32768};
      // both sides of the 4/11, 8/11 and 10/11 segment limits
      bounce_edge = '{17'd23831, 17'd23832, 17'd47662, 17'd47663, 17'd59578, 17'd59579};
      tracker = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // sender idles often, receiver idles most of the time
      send_idle_pct = 36;
      recv_idle_pct = 83;

      // every selector, including unused codes, at the time extremes and midpoint with full-scale values
      for (int k = 0; k < 16; k++) begin
         fn = 4'(k);
         if (k % 2 == 0) begin
            send_item(fn, corner_t[k % 4], VALUE_MIN, VALUE_MAX);
         end else begin
            send_item(fn, corner_t[k % 4], VALUE_MAX, VALUE_MIN);
         end
      end
      foreach (bounce_edge[i]) begin
         send_item(FUNC_OUTBOUNCE, bounce_edge[i], 32'sd0, 32'sh0064_0000);
      end
      // back overshoot past the 32-bit range, high and low
      send_item(FUNC_OUTBACK, 17'd40000, VALUE_MIN, VALUE_MAX);
      send_item(FUNC_INOUTBACK, 17'd20000, VALUE_MIN, VALUE_MAX);
      // go-and-back on either side of the turn
      send_item(FUNC_GOBACK, 17'd32767, -32'sd1000, 32'sd5000);
      send_item(FUNC_GOBACK, 17'd32768, -32'sd1000, 32'sd5000);

      repeat (360) send_random_item();

      // swap who idles
      send_idle_pct = 83;
      recv_idle_pct = 36;
      repeat (370) send_random_item();

      // no idling; hold the receiver off for a long stretch while items keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_hold_req = 1'b1;
      repeat (370) send_random_item();
      req_tvalid <= 1'b0;

      // drain, then give the pipeline time to show any stray result
      while (tracker.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (30) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
